@@ design/ctt_pkg.sv @@
package ctt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int ID_BITS     = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int EMIT_W  = $clog2(MAX_RESULTS + 1);
  localparam int COUNT_W = 17;
  localparam int CMP_W   = (ID_BITS > 16) ? ID_BITS : 16;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [EMIT_W-1:0]   emit_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [CMP_W-1:0]    cmp_t;
  typedef logic [CQ_PTR_W-1:0] cq_ptr_t;
  typedef logic [CQ_PTR_W:0]   cq_fill_t;
  typedef logic [RQ_PTR_W-1:0] rq_ptr_t;
  typedef logic [RQ_PTR_W:0]   rq_fill_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] duration;
    logic [15:0] cancel_id;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic        ok;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_REJECT,
    OP_CANCEL,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] duration;
    logic [15:0] cancel_id;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  function automatic logic [15:0] out_id(input id_t id);
    cmp_t w;
    w = cmp_t'(id);
    return w[15:0];
  endfunction

  function automatic id_t next_id(input id_t cur);
    id_t n;
    n = cur + id_t'(1);
    if (n == '0) begin
      n = id_t'(1);
    end
    return n;
  endfunction

endpackage

@@ design/countdown_timer_table.sv @@
// channel   direction  handshake           payload
// request   in         push / full         item   (func, duration, cancel_id)
// result    out        pop / empty         result (kind, timer_id, ok, last)
//
// start requests are answered at dispatch; cancel and tick take the dispatch,
// a sweep of the timer table one entry per cycle unless a full result queue
// holds a tick sweep, an end check and the reply
// a two-deep request queue lets requests arrive while a sweep runs
// a four-deep result queue decouples the sweep; a full result queue stalls it
// rst is synchronous; it empties the table, both queues and the id counter
module countdown_timer_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  ctt_pkg::item_t   item,
  input  logic             pop,
  output logic             empty,
  output ctt_pkg::result_t result
);

  logic             cmd_empty;
  logic             cmd_pop;
  ctt_pkg::cmd_t    cmd;
  logic             res_full;
  logic             res_push;
  ctt_pkg::result_t res_out;

  ctt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  ctt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_out)
  );

  ctt_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_out),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

@@ design/ctt_front.sv @@
module ctt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ctt_pkg::item_t item,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output ctt_pkg::cmd_t  cmd
);

  ctt_pkg::cmd_t     q [ctt_pkg::CQ_DEPTH];
  ctt_pkg::cq_ptr_t  wp;
  ctt_pkg::cq_ptr_t  rp;
  ctt_pkg::cq_fill_t fill;
  ctt_pkg::cmd_t     cls;
  logic              keep;
  logic              wr_en;
  logic              rd_en;

  // classify the request; unused function codes are dropped
  always_comb begin
    cls.duration  = item.duration;
    cls.cancel_id = item.cancel_id;
    keep          = 1'b1;
    case (item.func)
      ctt_pkg::FUNC_START: begin
        cls.op = (item.duration == '0) ? ctt_pkg::OP_REJECT : ctt_pkg::OP_START;
      end
      ctt_pkg::FUNC_CANCEL: begin
        cls.op = ctt_pkg::OP_CANCEL;
      end
      ctt_pkg::FUNC_TICK: begin
        cls.op = ctt_pkg::OP_TICK;
      end
      default: begin
        cls.op = ctt_pkg::OP_TICK;
        keep   = 1'b0;
      end
    endcase
  end

  assign full      = (fill == ctt_pkg::cq_fill_t'(ctt_pkg::CQ_DEPTH));
  assign cmd_empty = (fill == '0);
  assign cmd       = q[rp];
  assign wr_en     = push && !full && keep;
  assign rd_en     = cmd_pop && !cmd_empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + ctt_pkg::cq_ptr_t'(1);
      end
      if (rd_en) begin
        rp <= rp + ctt_pkg::cq_ptr_t'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + ctt_pkg::cq_fill_t'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - ctt_pkg::cq_fill_t'(1);
      end
    end
  end

endmodule

@@ design/ctt_resq.sv @@
module ctt_resq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  ctt_pkg::result_t res_in,
  output logic             res_full,
  input  logic             pop,
  output logic             empty,
  output ctt_pkg::result_t result
);

  ctt_pkg::result_t  q [ctt_pkg::RQ_DEPTH];
  ctt_pkg::rq_ptr_t  wp;
  ctt_pkg::rq_ptr_t  rp;
  ctt_pkg::rq_fill_t fill;
  logic              wr_en;
  logic              rd_en;

  assign res_full = (fill == ctt_pkg::rq_fill_t'(ctt_pkg::RQ_DEPTH));
  assign empty    = (fill == '0);
  assign result   = q[rp];
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + ctt_pkg::rq_ptr_t'(1);
      end
      if (rd_en) begin
        rp <= rp + ctt_pkg::rq_ptr_t'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + ctt_pkg::rq_fill_t'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - ctt_pkg::rq_fill_t'(1);
      end
    end
  end

endmodule

@@ design/ctt_engine.sv @@
module ctt_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  ctt_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output ctt_pkg::result_t res_out
);

  ctt_pkg::count_t cnt [ctt_pkg::NUM_SLOTS];
  ctt_pkg::id_t    ids [ctt_pkg::NUM_SLOTS];

  ctt_pkg::state_t state, state_next;
  ctt_pkg::op_t    op, op_next;
  ctt_pkg::cnt_t   live, live_next;
  ctt_pkg::cnt_t   rd, rd_next;
  ctt_pkg::cnt_t   wr, wr_next;
  ctt_pkg::id_t    id_counter, id_counter_next;
  ctt_pkg::emit_t  emitted, emitted_next;
  logic            found, found_next;
  logic            pend_v, pend_v_next;
  ctt_pkg::id_t    pend_id, pend_id_next;
  logic [15:0]     key, key_next;

  logic            we;
  ctt_pkg::cnt_t   we_idx;
  ctt_pkg::count_t we_cnt;
  ctt_pkg::id_t    we_id;

  ctt_pkg::count_t rd_cnt;
  ctt_pkg::id_t    rd_id;
  ctt_pkg::id_t    new_id;
  logic            expire;

  assign rd_cnt = cnt[rd[ctt_pkg::IDX_W-1:0]];
  assign rd_id  = ids[rd[ctt_pkg::IDX_W-1:0]];
  assign new_id = ctt_pkg::next_id(id_counter);
  assign expire = (rd_cnt <= ctt_pkg::count_t'(1)) &&
                  (emitted < ctt_pkg::emit_t'(ctt_pkg::MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ctt_pkg::ST_IDLE;
      op         <= ctt_pkg::OP_TICK;
      live       <= '0;
      rd         <= '0;
      wr         <= '0;
      id_counter <= '0;
      emitted    <= '0;
      found      <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      state      <= state_next;
      op         <= op_next;
      live       <= live_next;
      rd         <= rd_next;
      wr         <= wr_next;
      id_counter <= id_counter_next;
      emitted    <= emitted_next;
      found      <= found_next;
      pend_v     <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_id <= pend_id_next;
    key     <= key_next;
    if (we) begin
      cnt[we_idx[ctt_pkg::IDX_W-1:0]] <= we_cnt;
      ids[we_idx[ctt_pkg::IDX_W-1:0]] <= we_id;
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    live_next       = live;
    rd_next         = rd;
    wr_next         = wr;
    id_counter_next = id_counter;
    emitted_next    = emitted;
    found_next      = found;
    pend_v_next     = pend_v;
    pend_id_next    = pend_id;
    key_next        = key;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res_out         = '0;
    we              = 1'b0;
    we_idx          = wr;
    we_cnt          = rd_cnt;
    we_id           = rd_id;

    case (state)
      ctt_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            ctt_pkg::OP_REJECT: begin
              if (!res_full) begin
                cmd_pop  = 1'b1;
                res_push = 1'b1;
                res_out  = '{kind: ctt_pkg::KIND_START, timer_id: '0, ok: 1'b0,
                             last: 1'b1};
              end
            end
            ctt_pkg::OP_START: begin
              if (!res_full) begin
                cmd_pop  = 1'b1;
                res_push = 1'b1;
                if (live == ctt_pkg::cnt_t'(ctt_pkg::NUM_SLOTS)) begin
                  res_out = '{kind: ctt_pkg::KIND_START, timer_id: '0, ok: 1'b0,
                              last: 1'b1};
                end else begin
                  we              = 1'b1;
                  we_idx          = live;
                  we_cnt          = ctt_pkg::count_t'(cmd.duration) +
                                    ctt_pkg::count_t'(1);
                  we_id           = new_id;
                  live_next       = live + ctt_pkg::cnt_t'(1);
                  id_counter_next = new_id;
                  res_out = '{kind: ctt_pkg::KIND_START,
                              timer_id: ctt_pkg::out_id(new_id), ok: 1'b1,
                              last: 1'b1};
                end
              end
            end
            ctt_pkg::OP_CANCEL, ctt_pkg::OP_TICK: begin
              cmd_pop      = 1'b1;
              op_next      = cmd.op;
              key_next     = cmd.cancel_id;
              rd_next      = '0;
              wr_next      = '0;
              found_next   = 1'b0;
              emitted_next = '0;
              pend_v_next  = 1'b0;
              state_next   = ctt_pkg::ST_SWEEP;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end

      ctt_pkg::ST_SWEEP: begin
        if (rd == live) begin
          state_next = ctt_pkg::ST_DONE;
        end else if (op == ctt_pkg::OP_TICK) begin
          if (expire) begin
            if (!(pend_v && res_full)) begin
              if (pend_v) begin
                res_push = 1'b1;
                res_out  = '{kind: ctt_pkg::KIND_EXPIRE,
                             timer_id: ctt_pkg::out_id(pend_id), ok: 1'b1,
                             last: 1'b0};
              end
              pend_v_next  = 1'b1;
              pend_id_next = rd_id;
              emitted_next = emitted + ctt_pkg::emit_t'(1);
              rd_next      = rd + ctt_pkg::cnt_t'(1);
            end
          end else begin
            we      = 1'b1;
            we_cnt  = (rd_cnt > ctt_pkg::count_t'(1)) ?
                      rd_cnt - ctt_pkg::count_t'(1) : ctt_pkg::count_t'(1);
            wr_next = wr + ctt_pkg::cnt_t'(1);
            rd_next = rd + ctt_pkg::cnt_t'(1);
          end
        end else begin
          if (!found && (ctt_pkg::cmp_t'(rd_id) == ctt_pkg::cmp_t'(key))) begin
            found_next = 1'b1;
          end else begin
            we      = 1'b1;
            wr_next = wr + ctt_pkg::cnt_t'(1);
          end
          rd_next = rd + ctt_pkg::cnt_t'(1);
        end
      end

      ctt_pkg::ST_DONE: begin
        if (!res_full) begin
          live_next  = wr;
          state_next = ctt_pkg::ST_IDLE;
          if (op == ctt_pkg::OP_TICK) begin
            res_push = pend_v;
            res_out  = '{kind: ctt_pkg::KIND_EXPIRE,
                         timer_id: ctt_pkg::out_id(pend_id), ok: 1'b1, last: 1'b1};
          end else begin
            res_push = 1'b1;
            res_out  = '{kind: ctt_pkg::KIND_CANCEL, timer_id: key, ok: found,
                         last: 1'b1};
          end
        end
      end

      default: begin
        state_next = ctt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
